@@ design/bdhc_pkg.sv @@
package bdhc_pkg;

  // Width of the wrapping millisecond timestamp.
  localparam int unsigned TimeWidth = 32;
  // Width of each threshold register.
  localparam int unsigned RegWidth = 24;
  // Width of the register index on the configuration port.
  localparam int unsigned CfgIndexWidth = 3;

  // Command codes of an input word.
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_INIT   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Release event codes.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_TAP     = 2'd1;
  localparam logic [1:0] EV_NETWORK = 2'd2;
  localparam logic [1:0] EV_FACTORY = 2'd3;

  // Live hold status codes.
  localparam logic [2:0] HOLD_NONE    = 3'd0;
  localparam logic [2:0] HOLD_SHORT   = 3'd1;
  localparam logic [2:0] HOLD_NEUTRAL = 3'd2;
  localparam logic [2:0] HOLD_NETWORK = 3'd3;
  localparam logic [2:0] HOLD_FACTORY = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_TAP_MIN  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_TAP_MAX  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_NETWORK  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_FACTORY  = 3'd4;

  // Threshold reset values.
  localparam logic [RegWidth-1:0] DEBOUNCE_RESET = 24'd50;
  localparam logic [RegWidth-1:0] TAP_MIN_RESET  = 24'd50;
  localparam logic [RegWidth-1:0] TAP_MAX_RESET  = 24'd1000;
  localparam logic [RegWidth-1:0] NETWORK_RESET  = 24'd5000;
  localparam logic [RegWidth-1:0] FACTORY_RESET  = 24'd10000;

  typedef logic [TimeWidth-1:0] time_t;

  // All threshold registers, in milliseconds.
  typedef struct packed {
    logic [RegWidth-1:0] debounce_time;
    logic [RegWidth-1:0] tap_min_time;
    logic [RegWidth-1:0] tap_max_time;
    logic [RegWidth-1:0] network_time;
    logic [RegWidth-1:0] factory_time;
  } cfg_t;

  // Debounce and press tracking state.
  typedef struct packed {
    logic  raw_level;
    logic  stable_level;
    time_t change_time;
    time_t press_start;
    logic  recovery_flag;
    logic  release_latched;
  } state_t;

  // Widen a threshold to the timestamp width for comparison.
  function automatic time_t widen(input logic [RegWidth-1:0] thr);
    return time_t'(thr);
  endfunction

  // Classify a completed hold; the order of the tests decides overlaps.
  function automatic logic [1:0] classify_release(input time_t held, input cfg_t cfg);
    logic [1:0] ev;
    priority if (held >= widen(cfg.factory_time)) begin
      ev = EV_FACTORY;
    end else if (held >= widen(cfg.network_time)) begin
      ev = EV_NETWORK;
    end else if ((held >= widen(cfg.tap_min_time)) && (held <= widen(cfg.tap_max_time))) begin
      ev = EV_TAP;
    end else begin
      ev = EV_NONE;
    end
    return ev;
  endfunction

  // Live status of a press that is still held.
  function automatic logic [2:0] live_status(input logic stable, input logic latched,
                                             input time_t held, input cfg_t cfg);
    logic [2:0] st;
    priority if (!stable || latched) begin
      st = HOLD_NONE;
    end else if (held >= widen(cfg.factory_time)) begin
      st = HOLD_FACTORY;
    end else if (held >= widen(cfg.network_time)) begin
      st = HOLD_NETWORK;
    end else if (held > widen(cfg.tap_max_time)) begin
      st = HOLD_NEUTRAL;
    end else begin
      st = HOLD_SHORT;
    end
    return st;
  endfunction

endpackage

@@ design/button_debounce_hold_classifier.sv @@
// A word held in the input register has its result written to the result register.
// Throughput: one word per cycle when out_stall is low; the state update is combinational
// between the input register and the result register, and the input register can take a
// new word while a result waits to be taken only if the input register is empty.
// Reset (synchronous, active high) empties both stages, clears the debounce state and the
// recovery flag, and loads the threshold registers with their default values.
module button_debounce_hold_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           cmd,
  input  logic                                 level,
  input  logic [31:0]                          now_time,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           event_res,
  output logic [2:0]                           hold_status,
  output logic                                 recovery,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdhc_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [bdhc_pkg::RegWidth-1:0]        cfg_data
);

  bdhc_pkg::cfg_t   cfg;
  bdhc_pkg::state_t state;
  bdhc_pkg::state_t state_next;

  logic            in_reg_valid;
  logic [1:0]      in_cmd;
  logic            in_level;
  bdhc_pkg::time_t in_now;
  logic            advance;

  logic [1:0]      event_next;
  logic [2:0]      hold_next;
  logic            recovery_next;

  bdhc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result stage moves when it is empty or its word is being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_cmd   <= cmd;
      in_level <= level;
      in_now   <= bdhc_pkg::time_t'(now_time);
    end
  end

  bdhc_step u_step (
    .cmd         (in_cmd),
    .level       (in_level),
    .now_time    (in_now),
    .state       (state),
    .cfg         (cfg),
    .state_next  (state_next),
    .event_res   (event_next),
    .hold_status (hold_next),
    .recovery    (recovery_next)
  );

  // State advances together with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_reg_valid && advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg_valid) begin
      event_res   <= event_next;
      hold_status <= hold_next;
      recovery    <= recovery_next;
    end
  end

endmodule

@@ design/bdhc_cfg.sv @@
module bdhc_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bdhc_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [bdhc_pkg::RegWidth-1:0]         cfg_data,
  output bdhc_pkg::cfg_t                        cfg
);

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  // Threshold register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= bdhc_pkg::DEBOUNCE_RESET;
      cfg.tap_min_time  <= bdhc_pkg::TAP_MIN_RESET;
      cfg.tap_max_time  <= bdhc_pkg::TAP_MAX_RESET;
      cfg.network_time  <= bdhc_pkg::NETWORK_RESET;
      cfg.factory_time  <= bdhc_pkg::FACTORY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bdhc_pkg::REG_DEBOUNCE: cfg.debounce_time <= cfg_data;
        bdhc_pkg::REG_TAP_MIN:  cfg.tap_min_time  <= cfg_data;
        bdhc_pkg::REG_TAP_MAX:  cfg.tap_max_time  <= cfg_data;
        bdhc_pkg::REG_NETWORK:  cfg.network_time  <= cfg_data;
        bdhc_pkg::REG_FACTORY:  cfg.factory_time  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/bdhc_step.sv @@
module bdhc_step (
  input  logic [1:0]          cmd,
  input  logic                level,
  input  bdhc_pkg::time_t     now_time,
  input  bdhc_pkg::state_t    state,
  input  bdhc_pkg::cfg_t      cfg,
  output bdhc_pkg::state_t    state_next,
  output logic [1:0]          event_res,
  output logic [2:0]          hold_status,
  output logic                recovery
);

  bdhc_pkg::time_t since_change;
  bdhc_pkg::time_t held_old;
  bdhc_pkg::time_t held_release;
  bdhc_pkg::time_t held_live;

  // The three elapsed times are independent, so they run side by side.
  assign since_change = now_time - state.change_time;
  assign held_old     = now_time - state.press_start;
  assign held_release = state.change_time - state.press_start;

  // Next state, release event and the elapsed time of the press after this word.
  always_comb begin
    state_next = state;
    event_res  = bdhc_pkg::EV_NONE;
    held_live  = held_old;
    unique case (cmd)
      bdhc_pkg::CMD_SAMPLE: begin
        priority if (level != state.raw_level) begin
          // A raw change only restarts the debounce timer.
          state_next.raw_level   = level;
          state_next.change_time = now_time;
        end else if (since_change < bdhc_pkg::widen(cfg.debounce_time)) begin
        end else if (level == state.stable_level) begin
        end else if (level) begin
          // Press accepted: time it from the last raw change.
          state_next.stable_level    = 1'b1;
          state_next.press_start     = state.change_time;
          state_next.release_latched = 1'b0;
          held_live                  = since_change;
        end else begin
          state_next.stable_level = 1'b0;
          if (!state.release_latched) begin
            state_next.release_latched = 1'b1;
            event_res = bdhc_pkg::classify_release(held_release, cfg);
          end
        end
      end
      bdhc_pkg::CMD_INIT: begin
        // Load the boot level; a held button requests recovery and latches.
        state_next.stable_level    = level;
        state_next.raw_level       = level;
        state_next.change_time     = now_time;
        state_next.press_start     = now_time;
        state_next.recovery_flag   = level;
        state_next.release_latched = level;
        held_live                  = '0;
      end
      bdhc_pkg::CMD_CLEAR: begin
        state_next.recovery_flag = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result fields report the state after this word.
  assign hold_status = bdhc_pkg::live_status(state_next.stable_level,
                                             state_next.release_latched, held_live, cfg);
  assign recovery    = state_next.recovery_flag;

endmodule
